// ----- rtl/core/rpp_pkg.sv -----
package rpp_pkg;

  // Widths of the result fields.
  localparam int WORD_W        = 32;
  localparam int CMD_W         = 8;
  localparam int ENTRY_TOTAL_W = 5;

  // Default configuration of the block.
  localparam int MAX_ENTRIES_DEF = 25;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Packet layout.
  localparam int ENTRY_BYTES = 20;
  localparam logic [6:0] UDP_HDR_BYTES = 7'd8;
  // UDP header plus the four-byte RIP header.
  localparam logic [6:0] FIXED_HDR_BYTES = 7'd12;

  // Result kinds.
  localparam logic KIND_ROUTE   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // One record per byte that causes results: a route entry, a verdict, or both.
  typedef struct packed {
    logic                     has_entry;
    logic                     has_verdict;
    logic [WORD_W-1:0]        addr;
    logic [WORD_W-1:0]        mask;
    logic [WORD_W-1:0]        next_hop;
    logic [WORD_W-1:0]        metric;
    logic                     ok;
    logic [CMD_W-1:0]         cmd;
    logic [ENTRY_TOTAL_W-1:0] total;
  } rpp_rec_t;

endpackage

// ----- rtl/core/rpp_front.sv -----
module rpp_front #(
  parameter int MAX_ENTRIES = rpp_pkg::MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             full,
  input  logic [7:0]       data_byte,
  input  logic             end_of_packet,
  output logic             push,
  output rpp_pkg::rpp_rec_t rec
);
  import rpp_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SH_LEN = ENTRY_BYTES - 1;

  // Positions of the IPv4 header bytes that are read.
  localparam logic [15:0] POS_IHL    = 16'd0;
  localparam logic [15:0] POS_LEN_HI = 16'd2;
  localparam logic [15:0] POS_LEN_LO = 16'd3;

  // Offsets inside the RIP header.
  localparam logic [1:0] RH_COMMAND = 2'd0;
  localparam logic [1:0] RH_VERSION = 2'd1;
  localparam logic [1:0] RH_ZERO_HI = 2'd2;
  localparam logic [1:0] RH_ZERO_LO = 2'd3;

  localparam logic [7:0]  CMD_REQUEST  = 8'd1;
  localparam logic [7:0]  CMD_RESPONSE = 8'd2;
  localparam logic [7:0]  RIP_VERSION  = 8'd2;
  localparam logic [15:0] FAMILY_ANY   = 16'd0;
  localparam logic [15:0] FAMILY_INET  = 16'd2;
  localparam logic [31:0] METRIC_MIN   = 32'd1;
  localparam logic [31:0] METRIC_INF   = 32'd16;
  localparam logic [4:0]  K_LAST       = 5'(ENTRY_BYTES - 1);

  logic [15:0]      pos, pos_next;
  logic [15:0]      tot, tot_next;
  logic [5:0]       hdr, hdr_next;
  logic [7:0]       cmd, cmd_next;
  logic             err, err_next;
  logic [4:0]       k, k_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [7:0]       sh [0:SH_LEN-1];

  logic             accept;
  logic [6:0]       start;
  logic             in_region;
  logic [15:0]      rel;
  logic             hdr_byte;
  logic             ent_byte;
  logic             ent_done;
  logic             emit;
  logic             hdr_bad;
  logic [7:0]       e [0:ENTRY_BYTES-1];
  logic [15:0]      fam;
  logic [15:0]      tag;
  logic [31:0]      met_be;
  logic [31:0]      inv;
  logic             good;
  logic             err_upd;
  logic [7:0]       cmd_upd;
  logic [CNT_W-1:0] cnt_upd;
  logic [6:0]       need;
  logic [15:0]      diff;
  logic             len_ok;
  logic             recv_ok;

  // Remainder by five of a 16-bit value: 16 is 1 modulo 5, so hex digits add up.
  function automatic logic [2:0] mod5(input logic [15:0] d);
    logic [5:0] s;
    logic [4:0] s2;
    logic [4:0] r;
    s  = 6'(d[3:0]) + 6'(d[7:4]) + 6'(d[11:8]) + 6'(d[15:12]);
    s2 = 5'(s[5:4]) + 5'(s[3:0]);
    if (s2 >= 5'd15) begin
      r = s2 - 5'd15;
    end else if (s2 >= 5'd10) begin
      r = s2 - 5'd10;
    end else if (s2 >= 5'd5) begin
      r = s2 - 5'd5;
    end else begin
      r = s2;
    end
    return r[2:0];
  endfunction

  assign accept = in_valid && !full;

  assign start     = {1'b0, hdr} + UDP_HDR_BYTES;
  assign in_region = (pos >= 16'(start)) && (pos < tot);
  assign rel       = pos - 16'(start);
  assign hdr_byte  = in_region && (rel[15:2] == '0);
  assign ent_byte  = in_region && !hdr_byte;
  assign ent_done  = ent_byte && (k == K_LAST);
  assign emit      = ent_done && (cnt < CNT_W'(MAX_ENTRIES));

  always_comb begin
    for (int i = 0; i < SH_LEN; i++) begin
      e[i] = sh[i];
    end
    e[ENTRY_BYTES-1] = data_byte;
  end

  assign fam    = {e[0], e[1]};
  assign tag    = {e[2], e[3]};
  assign met_be = {e[16], e[17], e[18], e[19]};
  assign inv    = ~{e[8], e[9], e[10], e[11]};
  assign good   = ((cmd == CMD_REQUEST && fam == FAMILY_ANY) ||
                   (cmd == CMD_RESPONSE && fam == FAMILY_INET)) &&
                  (tag == '0) && (met_be >= METRIC_MIN) && (met_be <= METRIC_INF) &&
                  ((inv & (inv + 32'd1)) == '0);

  always_comb begin
    hdr_bad = 1'b0;
    cmd_upd = cmd;
    unique case (rel[1:0]) inside
      RH_COMMAND: begin
        cmd_upd = data_byte;
        hdr_bad = (data_byte != CMD_REQUEST) && (data_byte != CMD_RESPONSE);
      end
      RH_VERSION: hdr_bad = (data_byte != RIP_VERSION);
      RH_ZERO_HI, RH_ZERO_LO: hdr_bad = (data_byte != '0);
      default: hdr_bad = 1'b0;
    endcase
    if (!hdr_byte) begin
      cmd_upd = cmd;
      hdr_bad = 1'b0;
    end
  end

  assign err_upd = err || hdr_bad || (ent_done && (!emit || !good));
  assign cnt_upd = emit ? cnt + 1'b1 : cnt;

  // The length checks use the registered lengths; before byte 4 they are not
  // complete, and such a short buffer can never meet its own total length.
  assign need    = {1'b0, hdr} + FIXED_HDR_BYTES;
  assign diff    = tot - 16'(need);
  assign len_ok  = (tot >= 16'(need)) && (diff[1:0] == '0) && (mod5(diff) == '0);
  assign recv_ok = ({1'b0, pos} + 17'd1) >= {1'b0, tot};

  always_comb begin
    pos_next = pos;
    tot_next = tot;
    hdr_next = hdr;
    cmd_next = cmd;
    err_next = err;
    k_next   = k;
    cnt_next = cnt;
    if (accept) begin
      if (pos == POS_IHL) begin
        hdr_next = {data_byte[3:0], 2'b00};
      end
      if (pos == POS_LEN_HI) begin
        tot_next = {data_byte, tot[7:0]};
      end
      if (pos == POS_LEN_LO) begin
        tot_next = {tot[15:8], data_byte};
      end
      cmd_next = cmd_upd;
      err_next = err_upd;
      cnt_next = cnt_upd;
      if (ent_byte) begin
        k_next = (k == K_LAST) ? '0 : k + 1'b1;
      end
      if (pos != '1) begin
        pos_next = pos + 1'b1;
      end
      if (end_of_packet) begin
        pos_next = '0;
        tot_next = '0;
        hdr_next = '0;
        cmd_next = '0;
        err_next = 1'b0;
        k_next   = '0;
        cnt_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      tot <= '0;
      hdr <= '0;
      cmd <= '0;
      err <= 1'b0;
      k   <= '0;
      cnt <= '0;
    end else begin
      pos <= pos_next;
      tot <= tot_next;
      hdr <= hdr_next;
      cmd <= cmd_next;
      err <= err_next;
      k   <= k_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ent_byte) begin
      for (int i = 0; i < SH_LEN - 1; i++) begin
        sh[i] <= sh[i+1];
      end
      sh[SH_LEN-1] <= data_byte;
    end
  end

  assign push = accept && (emit || end_of_packet);

  always_comb begin
    rec.has_entry   = emit;
    rec.has_verdict = end_of_packet;
    rec.addr        = {e[7], e[6], e[5], e[4]};
    rec.mask        = {e[11], e[10], e[9], e[8]};
    rec.next_hop    = {e[15], e[14], e[13], e[12]};
    rec.metric      = {e[19], e[18], e[17], e[16]};
    rec.ok          = !err_upd && (pos[15:2] != '0) && recv_ok && len_ok;
    rec.cmd         = cmd_upd;
    rec.total       = ENTRY_TOTAL_W'(cnt_upd);
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_ENTRIES))
    else $error("entry count passed its limit");

  a_ent_counter: assert property (@(posedge clk) disable iff (rst)
    k <= K_LAST)
    else $error("entry byte counter out of range");

endmodule

// ----- rtl/core/rpp_queue.sv -----
module rpp_queue #(
  parameter int DEPTH = rpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rpp_pkg::rpp_rec_t wr_rec,
  input  logic              pop,
  output logic              head_valid,
  output rpp_pkg::rpp_rec_t head,
  output logic              full
);
  import rpp_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rpp_rec_t         store [0:DEPTH-1];
  logic [IDX_W-1:0] wr_ptr, wr_ptr_next;
  logic [IDX_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;

  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(DEPTH));
  assign head       = store[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("record written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("record taken from an empty queue");

endmodule

// ----- rtl/core/rpp_back.sv -----
module rpp_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   head_valid,
  input  rpp_pkg::rpp_rec_t                      head,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   result_kind,
  output logic [rpp_pkg::WORD_W-1:0]             route_addr,
  output logic [rpp_pkg::WORD_W-1:0]             route_mask,
  output logic [rpp_pkg::WORD_W-1:0]             route_next_hop,
  output logic [rpp_pkg::WORD_W-1:0]             route_metric,
  output logic                                   packet_ok,
  output logic [rpp_pkg::CMD_W-1:0]              rip_command,
  output logic [rpp_pkg::ENTRY_TOTAL_W-1:0]      entry_total,
  output logic                                   run_end
);
  import rpp_pkg::*;

  logic load;
  logic emit_entry;
  logic verdict_pending;

  assign load       = !out_valid || !out_stall;
  assign emit_entry = head.has_entry && !verdict_pending;
  // A record with both an entry and a verdict stays at the head for two words.
  assign pop        = load && head_valid && !(emit_entry && head.has_verdict);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      verdict_pending <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        verdict_pending <= emit_entry && head.has_verdict;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (emit_entry) begin
        result_kind    <= KIND_ROUTE;
        route_addr     <= head.addr;
        route_mask     <= head.mask;
        route_next_hop <= head.next_hop;
        route_metric   <= head.metric;
        packet_ok      <= 1'b0;
        rip_command    <= '0;
        entry_total    <= '0;
        run_end        <= !head.has_verdict;
      end else begin
        result_kind    <= KIND_VERDICT;
        route_addr     <= '0;
        route_mask     <= '0;
        route_next_hop <= '0;
        route_metric   <= '0;
        packet_ok      <= head.ok;
        rip_command    <= head.cmd;
        entry_total    <= head.total;
        run_end        <= 1'b1;
      end
    end
  end

  a_pending_pair: assert property (@(posedge clk) disable iff (rst)
    verdict_pending |-> (head_valid && head.has_entry && head.has_verdict))
    else $error("verdict pending without a paired record at the head");

endmodule

// ----- rtl/core/rip_packet_parser_top.sv -----
// RIPv2 packet parser. Bytes of an IPv4 packet that carries UDP and RIPv2 enter
// one word per cycle on the input channel while in_stall is low, starting at
// the first IPv4 header byte. The parser checks the RIP header and every
// 20-byte route entry that lies wholly inside the IPv4 total length, and
// sends each of the first MAX_ENTRIES entries out as its last byte arrives.
// The byte flagged end_of_packet also yields a verdict word with the command,
// the entry count and packet_ok, and the parser is then ready for the next
// packet. A byte that both completes an entry and ends the packet sends two
// words. A result is first registered in a queue of QUEUE_DEPTH entries, into
// which the front parser writes a record, and then in the output register.
// in_stall rises only when that queue is full, so the input keeps moving
// while a finished word waits on out_stall. run_end marks the last word
// caused by one byte.
module rip_packet_parser_top #(
  parameter int MAX_ENTRIES = rpp_pkg::MAX_ENTRIES_DEF,
  parameter int QUEUE_DEPTH = rpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              end_of_packet,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              result_kind,
  output logic [rpp_pkg::WORD_W-1:0]        route_addr,
  output logic [rpp_pkg::WORD_W-1:0]        route_mask,
  output logic [rpp_pkg::WORD_W-1:0]        route_next_hop,
  output logic [rpp_pkg::WORD_W-1:0]        route_metric,
  output logic                              packet_ok,
  output logic [rpp_pkg::CMD_W-1:0]         rip_command,
  output logic [rpp_pkg::ENTRY_TOTAL_W-1:0] entry_total,
  output logic                              run_end
);
  import rpp_pkg::*;

  // Front to queue.
  logic     push;
  rpp_rec_t wr_rec;
  logic     full;

  // Queue to back.
  logic     head_valid;
  rpp_rec_t head;
  logic     pop;

  // The input stalls only on a full queue, never on the output side directly.
  assign in_stall = full;

  rpp_front #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .full         (full),
    .data_byte    (data_byte),
    .end_of_packet(end_of_packet),
    .push         (push),
    .rec          (wr_rec)
  );

  rpp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_rec    (wr_rec),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head),
    .full      (full)
  );

  rpp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .route_addr    (route_addr),
    .route_mask    (route_mask),
    .route_next_hop(route_next_hop),
    .route_metric  (route_metric),
    .packet_ok     (packet_ok),
    .rip_command   (rip_command),
    .entry_total   (entry_total),
    .run_end       (run_end)
  );

  // A route word never carries verdict fields.
  a_route_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_ROUTE) |-> (!packet_ok && entry_total == '0))
    else $error("route word carries verdict fields");

  // A verdict always closes the run of words caused by its byte.
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_VERDICT) |-> run_end)
    else $error("verdict word not marked as last of its run");

endmodule
